@@ rtl/core/dbb_pkg.sv @@
// Shared types and constants for the dilated box blur block.
// Used by dbb_ctrl, dbb_datapath and dilated_box_blur_rgb_top.
package dbb_pkg;

  localparam int unsigned DEF_MAX_WIDTH    = 2048;
  localparam int unsigned DEF_MAX_DILATION = 3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DILATION = 2'd2;

  localparam int unsigned RAW_W_W   = 12;
  localparam int unsigned RAW_H_W   = 13;
  localparam int unsigned RAW_D_W   = 2;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned HW        = 13;

  localparam int unsigned NUM_TAPS  = 9;
  localparam int unsigned CENTRE_TAP = 4;
  localparam int unsigned TAP_W     = 4;
  localparam int unsigned SUM_W     = 12;   // 9 * 255 fits
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned REM_W     = 5;
  localparam int unsigned PIX_W     = 32;

  // Tap position inside the 3x3 grid: 0 = minus d, 1 = centre, 2 = plus d
  localparam logic [1:0] POS_NEG = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_POS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_TAP,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } dbb_state_e;

  typedef struct packed {
    logic             capture;
    logic             eval;
    logic             tap_issue;
    logic [TAP_W-1:0] tap_idx;
    logic             div_load;
    logic             div_step;
    logic             load_out;
  } dbb_cmd_t;

  typedef struct packed {
    logic due;
    logic out_free;
  } dbb_sts_t;

  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2: r = POS_NEG;
      4'd3, 4'd4, 4'd5: r = POS_MID;
      default:          r = POS_POS;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] idx);
    logic [1:0] c;
    case (idx)
      4'd0, 4'd3, 4'd6: c = POS_NEG;
      4'd1, 4'd4, 4'd7: c = POS_MID;
      default:          c = POS_POS;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/dbb_ctrl.sv @@
// Sequencer for the dilated box blur: item intake, tap reads, divide, emit.
// Depends on dbb_pkg; drives dbb_datapath through dbb_cmd_t.
module dbb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dbb_pkg::dbb_sts_t sts_i,
  output dbb_pkg::dbb_cmd_t cmd_o
);
  import dbb_pkg::*;

  dbb_state_e       state_q, state_d;
  logic [TAP_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.due ? ST_TAP : ST_IDLE;
      end
      ST_TAP: begin
        cmd_o.tap_issue = 1'b1;
        cmd_o.tap_idx   = cnt_q;
        if (cnt_q == TAP_W'(NUM_TAPS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: state_d = ST_LOAD;
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == TAP_W'(SUM_W - 1)) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/dbb_datapath.sv @@
// Datapath of the dilated box blur: registers, counters, line store,
// tap accumulators, bit-serial divider and output register. Uses dbb_pkg.
module dbb_datapath #(
  parameter int unsigned MAX_WIDTH    = dbb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_DILATION = dbb_pkg::DEF_MAX_DILATION
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [dbb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dbb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_cmd_i,
  input  logic [dbb_pkg::PIX_W-1:0]       in_pix_i,
  input  dbb_pkg::dbb_cmd_t               cmd_i,
  output dbb_pkg::dbb_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dbb_pkg::PIX_W-1:0]       out_pix_o,
  output logic                            out_last_o
);
  import dbb_pkg::*;

  localparam int unsigned RING = 2 * MAX_DILATION * MAX_WIDTH + 2 * MAX_DILATION + 1;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW   = $clog2(MAX_DILATION + 1);
  localparam int unsigned TW   = WW + HW;
  localparam int unsigned DWW  = $clog2(MAX_DILATION * MAX_WIDTH + 1);

  // configuration
  logic [RAW_W_W-1:0] w_q;
  logic [RAW_H_W-1:0] h_q;
  logic [RAW_D_W-1:0] d_q;
  logic [WW-1:0]      effw_q, effw_d;
  logic [HW-1:0]      effh_q, effh_d;
  logic [DW-1:0]      effd_q, effd_d;
  logic [TW-1:0]      total_q, lag_q;
  logic [DWW-1:0]     dw_q;
  logic               cfg_hit;

  // frame position
  logic [TW-1:0] in_cnt_q, out_idx_q;
  logic [AW-1:0] wr_ptr_q, out_ptr_q;
  logic [HW-1:0] out_row_q;
  logic [WW-1:0] out_col_q;

  // captured item
  logic             item_cmd_q;
  logic [PIX_W-1:0] item_pix_q;

  logic [PIX_W-1:0] mem [RING];
  logic [PIX_W-1:0] rd_q;

  logic wr_ok;
  logic [TW-1:0] n_new;
  logic [TW:0]   due_lim;

  assign cfg_hit = cfg_valid_i && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT ||
                                   cfg_index_i == CFG_DILATION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= RAW_W_W'(640);
      h_q <= RAW_H_W'(480);
      d_q <= RAW_D_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:    w_q <= cfg_data_i[RAW_W_W-1:0];
        CFG_HEIGHT:   h_q <= cfg_data_i[RAW_H_W-1:0];
        CFG_DILATION: d_q <= cfg_data_i[RAW_D_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (w_q == '0) effw_d = WW'(1);
    else if (14'(w_q) > 14'(MAX_WIDTH)) effw_d = WW'(MAX_WIDTH);
    else effw_d = WW'(w_q);
    if (h_q == '0) effh_d = HW'(1);
    else if (14'(h_q) > 14'(HEIGHT_LIMIT)) effh_d = HW'(HEIGHT_LIMIT);
    else effh_d = h_q;
    if (d_q == '0) effd_d = DW'(1);
    else if (4'(d_q) > 4'(MAX_DILATION)) effd_d = DW'(MAX_DILATION);
    else effd_d = DW'(d_q);
  end

  // Derived sizes are registered from the clamped configuration registers.
  always_ff @(posedge clk_i) begin
    effw_q  <= effw_d;
    effh_q  <= effh_d;
    effd_q  <= effd_d;
    total_q <= TW'(effw_d) * TW'(effh_d);
    dw_q    <= DWW'(effd_d) * DWW'(effw_d);
    lag_q   <= TW'(effd_d) * TW'(effw_d) + TW'(effd_d);
  end

  assign wr_ok   = !item_cmd_q && (in_cnt_q < total_q);
  assign n_new   = in_cnt_q + TW'(wr_ok);
  assign due_lim = (TW + 1)'(out_idx_q) + (TW + 1)'(lag_q);
  assign sts_o.due = (out_idx_q < total_q) &&
                     ((n_new == total_q) || ((TW + 1)'(n_new) > due_lim));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_cmd_q <= in_cmd_i;
      item_pix_q <= in_pix_i;
    end
  end

  // tap address and bounds
  logic [1:0]           tr, tc;
  logic signed [AW+1:0] roff, coff, sa, addr_s;
  logic [AW-1:0]        tap_addr;
  logic signed [HW+1:0] rr;
  logic signed [WW+1:0] cc;
  logic                 tap_vld;

  always_comb begin
    tr = tap_row(cmd_i.tap_idx);
    tc = tap_col(cmd_i.tap_idx);
    case (tr)
      POS_NEG: roff = -$signed((AW + 2)'(dw_q));
      POS_POS: roff = $signed((AW + 2)'(dw_q));
      default: roff = '0;
    endcase
    case (tc)
      POS_NEG: coff = -$signed((AW + 2)'(effd_q));
      POS_POS: coff = $signed((AW + 2)'(effd_q));
      default: coff = '0;
    endcase
    sa = $signed((AW + 2)'(out_ptr_q)) + roff + coff;
    if (sa < 0) addr_s = sa + $signed((AW + 2)'(RING));
    else if (sa >= $signed((AW + 2)'(RING))) addr_s = sa - $signed((AW + 2)'(RING));
    else addr_s = sa;
    tap_addr = addr_s[AW-1:0];
    case (tr)
      POS_NEG: rr = $signed((HW + 2)'(out_row_q)) - $signed((HW + 2)'(effd_q));
      POS_POS: rr = $signed((HW + 2)'(out_row_q)) + $signed((HW + 2)'(effd_q));
      default: rr = $signed((HW + 2)'(out_row_q));
    endcase
    case (tc)
      POS_NEG: cc = $signed((WW + 2)'(out_col_q)) - $signed((WW + 2)'(effd_q));
      POS_POS: cc = $signed((WW + 2)'(out_col_q)) + $signed((WW + 2)'(effd_q));
      default: cc = $signed((WW + 2)'(out_col_q));
    endcase
    tap_vld = (rr >= 0) && (rr < $signed((HW + 2)'(effh_q))) &&
              (cc >= 0) && (cc < $signed((WW + 2)'(effw_q)));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && wr_ok) mem[wr_ptr_q] <= item_pix_q;
    if (cmd_i.tap_issue) rd_q <= mem[tap_addr];
  end

  // accumulate one tap per cycle, in the cycle after the read
  logic             pend_q, pvld_q, pctr_q;
  logic [SUM_W-1:0] sum_q [3];
  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else pend_q <= cmd_i.tap_issue;
  end

  always_ff @(posedge clk_i) begin
    pvld_q <= tap_vld;
    pctr_q <= (cmd_i.tap_idx == TAP_W'(CENTRE_TAP));
    if (cmd_i.eval) begin
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
      cnt_q <= '0;
    end else if (pend_q && pvld_q) begin
      for (int i = 0; i < 3; i++) sum_q[i] <= sum_q[i] + SUM_W'(rd_q[8*i +: 8]);
      cnt_q <= cnt_q + 1'b1;
    end
    if (pend_q && pctr_q) alpha_q <= rd_q[31:24];
  end

  // restoring divider, one quotient bit per cycle for all three channels
  logic [SUM_W-1:0] quo_q [3];
  logic [REM_W-1:0] rem_q [3];
  logic [REM_W-1:0] trial [3];

  always_comb begin
    for (int i = 0; i < 3; i++) trial[i] = {rem_q[i][REM_W-2:0], quo_q[i][SUM_W-1]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      for (int i = 0; i < 3; i++) begin
        quo_q[i] <= sum_q[i];
        rem_q[i] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if (trial[i] >= REM_W'(cnt_q)) begin
          rem_q[i] <= trial[i] - REM_W'(cnt_q);
          quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= trial[i];
          quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register and frame counters
  logic             m_valid_q;
  logic [PIX_W-1:0] m_pix_q;
  logic             m_last_q;
  logic             last_px;

  assign sts_o.out_free = !m_valid_q || out_ready_i;
  assign last_px = (out_idx_q + 1'b1) == total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      m_pix_q  <= {alpha_q, quo_q[2][7:0], quo_q[1][7:0], quo_q[0][7:0]};
      m_last_q <= last_px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_idx_q <= '0;
      wr_ptr_q  <= '0;
      out_ptr_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_hit || (cmd_i.load_out && last_px)) begin
      in_cnt_q  <= '0;
      out_idx_q <= '0;
      wr_ptr_q  <= '0;
      out_ptr_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      if (cmd_i.eval && wr_ok) begin
        in_cnt_q <= n_new;
        wr_ptr_q <= (wr_ptr_q == AW'(RING - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_idx_q <= out_idx_q + 1'b1;
        out_ptr_q <= (out_ptr_q == AW'(RING - 1)) ? '0 : out_ptr_q + 1'b1;
        if (out_col_q == effw_q - 1'b1) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_pix_o   = m_pix_q;
  assign out_last_o  = m_last_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!m_valid_q || out_ready_i))
    else $error("result loaded over a pending one");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tap_issue |-> (addr_s >= 0 && addr_s < $signed((AW + 2)'(RING))))
    else $error("tap address outside line store");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_load |-> (cnt_q != '0))
    else $error("divide with no taps counted");

endmodule

@@ rtl/core/dilated_box_blur_rgb_top.sv @@
// Top level of the dilated 3x3 box blur over an RGBA pixel stream.
// Instantiates dbb_ctrl and dbb_datapath; types from dbb_pkg.
//
// Usage:
//   Slave stream: tdata = red, green, blue, alpha (bits 7:0 up to 31:24),
//   tuser = command (0 pixel, 1 flush tick). Master stream: tdata = blurred
//   red, green, blue and centre alpha; tlast marks the frame's last pixel.
//   Configuration channel: cfg_index_i 0 width, 1 height, 2 dilation; any of
//   these writes restarts the frame. Write only while the block is idle.
//   Results for pixel q appear once pixel q + d*W + d is in; after the last
//   pixel send flush ticks (or further pixels, which are dropped) to drain.
// Sequence:
//   An item that yields no result is accepted and evaluated. One that yields
//   a result goes through accept, evaluate, nine reads from the single-port
//   line store, a drain step, the divider load, a bit-serial divide over the
//   12-bit channel sums and the output load.
//   The next item is taken while a result waits in the output register; the
//   block holds only when a new result is ready and the old one is not taken.
// Reset: control state clears, registers return to 640 x 480, d = 1. The line
//   store is not cleared; only taps inside the frame are accumulated.
module dilated_box_blur_rgb_top #(
  parameter int unsigned MAX_WIDTH    = dbb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_DILATION = dbb_pkg::DEF_MAX_DILATION
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dbb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // red, green, blue, alpha
  input  logic                           s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // red, green, blue, alpha
  output logic                           m_axis_tlast   // frame_end
);
  import dbb_pkg::*;

  dbb_cmd_t cmd;
  dbb_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbb_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_DILATION (MAX_DILATION)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (s_axis_tuser),
    .in_pix_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
